// ----- rtl/core/drhf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// drhf_pkg: shared types and constants for the heading fusion block
// Holds the payload structs, register indexes, motion codes and the
// controller-to-datapath command and status types.
// ----------------------------------------------------------------------------
package drhf_pkg;

  localparam int TRIG_TABLE_BITS_DEF = 10;

  // Heading units are 1/256 degree
  localparam int FULL_TURN = 92160;
  localparam int HALF_TURN = 46080;
  localparam int SPEED_MAX = 19661;

  // floor(2^27 / 45), used for the divide by 92160 (2^11 * 45)
  localparam logic [22:0] RECIP_45 = 23'd2982616;

  localparam logic [1:0] MODE_STOPPED  = 2'd0;
  localparam logic [1:0] MODE_STRAIGHT = 2'd1;

  localparam logic [4:0] LAST_STEP = 5'd29;

  typedef enum logic [2:0] {
    REG_MOTION_MODE   = 3'd0,
    REG_ACCEL_ZERO_X  = 3'd1,
    REG_ACCEL_ZERO_Y  = 3'd2,
    REG_GYRO_ZERO_Z   = 3'd3,
    REG_ACCEL_SCALE   = 3'd4,
    REG_GYRO_SCALE    = 3'd5,
    REG_START_HEADING = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic        [16:0] compass_heading;
    logic signed [15:0] accel_raw_x;
    logic signed [15:0] accel_raw_y;
    logic signed [15:0] gyro_raw_z;
  } in_item_t;

  typedef struct packed {
    logic        [16:0] heading_out;
    logic signed [23:0] accel_north;
    logic signed [23:0] accel_west;
    logic signed [15:0] speed_north;
    logic signed [15:0] speed_west;
    logic signed [31:0] position_north;
    logic signed [31:0] position_west;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_PREP, OP_MUL_G, OP_GC, OP_AX, OP_AY, OP_RED, OP_HDG,
    OP_IDX_MUL, OP_IDX_FIX, OP_P1, OP_P2, OP_P3, OP_P4, OP_P5,
    OP_R1, OP_R2, OP_R3, OP_R4, OP_R5, OP_INT1, OP_INT2
  } dp_op_t;

  typedef struct packed {
    logic       capture;
    dp_op_t     op;
    logic [2:0] red_k;
    logic       trig_sel;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic stopped;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/core/drhf_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// drhf_dp: heading fusion datapath
// Configuration registers, navigation state, one shared 27x23 multiplier and
// the per-step arithmetic selected by the controller command.
// ----------------------------------------------------------------------------
module drhf_dp import drhf_pkg::*; #(
  parameter int TRIG_TABLE_BITS = TRIG_TABLE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [16:0] cfg_data,
  input  wire in_item_t   in_data,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      status,
  output out_item_t       out_data
);

  localparam int B  = TRIG_TABLE_BITS;
  localparam int NW = 18 + B;
  localparam int MW = B + 7;
  localparam logic [B-2:0] QLEN = (B-1)'(1) << (B - 2);

  // Configuration
  logic        [1:0]  mode;
  logic signed [15:0] zero_x, zero_y, zero_g;
  logic        [15:0] a_scale, g_scale;

  // Navigation state
  logic        [16:0] heading;
  logic signed [23:0] accel0, accel1;
  logic signed [15:0] speed0, speed1;
  logic        [31:0] pos0, pos1;

  // Work registers
  in_item_t           in_reg;
  logic signed [16:0] gd, axd, ayd;
  logic signed [17:0] cc;
  logic signed [22:0] gc;
  logic signed [25:0] axs, ays;
  logic signed [24:0] hsum;
  logic        [22:0] x;
  logic               w_neg, w_pos;
  logic    [MW-1:0]   m_reg;
  logic     [B-1:0]   idx;
  logic        [16:0] u;
  logic               u_full, s_neg;
  logic        [15:0] u2;
  logic signed [17:0] sin_v, cos_v;
  logic signed [49:0] acc;
  logic signed [23:0] an0, an1;
  logic signed [15:0] vn0, vn1;
  logic signed [49:0] p;

  // Multiplier operands
  logic signed [26:0] ma;
  logic signed [22:0] mb;

  // Combinational helpers
  logic signed [16:0] g_diff, ax_diff, ay_diff;
  logic signed [17:0] c_diff, c_wrap;
  logic signed [49:0] gtmp, rtmp, rsum;
  logic        [17:0] abs_cc;
  logic        [22:0] abs_gc;
  logic signed [23:0] avg_sum;
  logic signed [24:0] hc, hs_c, x_c;
  logic        [22:0] red_c;
  logic    [NW-1:0]   n_c;
  logic    [MW-1:0]   m_c, q45, rem;
  logic     [B:0]     q0, qf;
  logic     [B-1:0]   angle;
  logic     [B-2:0]   rr;
  logic        [16:0] u_c, t1, t2;
  logic        [17:0] s_raw, s_cap;

  function automatic logic signed [23:0] sat24(input logic signed [49:0] v);
    logic signed [33:0] r;
    r = v[49:16];
    if (r > 34'sd8388607) return 24'sd8388607;
    if (r < -34'sd8388608) return -24'sd8388608;
    return r[23:0];
  endfunction

  function automatic logic signed [15:0] vel(input logic signed [23:0] a_old,
                                             input logic signed [23:0] a_new,
                                             input logic signed [15:0] v);
    logic signed [25:0] s;
    logic signed [21:0] t;
    s = 26'(a_old) + 26'(a_new) + 26'sd8;
    t = 22'(s >>> 4) + 22'(v);
    if (t > 22'sd19661) return 16'sd19661;
    if (t < -22'sd19661) return -16'sd19661;
    return t[15:0];
  endfunction

  function automatic logic [31:0] pstep(input logic signed [15:0] v_old,
                                        input logic signed [15:0] v_new);
    logic signed [16:0] s;
    s = 17'(v_old) + 17'(v_new) + 17'sd8;
    return 32'(s >>> 4);
  endfunction

  assign status.stopped = (mode == MODE_STOPPED);

  // Sample offsets and wrapped compass change
  always_comb begin
    g_diff  = 17'(in_reg.gyro_raw_z) - 17'(zero_g);
    ax_diff = 17'(in_reg.accel_raw_x) - 17'(zero_x);
    ay_diff = 17'(in_reg.accel_raw_y) - 17'(zero_y);
    c_diff  = 18'($signed({1'b0, in_reg.compass_heading})) - 18'($signed({1'b0, heading}));
    if (c_diff > 18'sd46080) c_wrap = c_diff - 18'sd92160;
    else if (c_diff < -18'sd46080) c_wrap = c_diff + 18'sd92160;
    else c_wrap = c_diff;
  end

  // Heading change fusion and wrap preparation
  always_comb begin
    gtmp    = -p + 50'sd1024;
    rtmp    = p + 50'sd128;
    abs_cc  = cc[17] ? 18'(-cc) : 18'(cc);
    abs_gc  = gc[22] ? 23'(-gc) : 23'(gc);
    avg_sum = 24'(cc) + 24'(gc);
    if (mode == MODE_STRAIGHT) begin
      hc = (abs_cc < 18'd1024) ? 25'(avg_sum >>> 1) : 25'(gc);
    end else begin
      hc = ({5'b0, abs_cc} < abs_gc) ? 25'(cc) : 25'(gc);
    end
    hs_c = 25'($signed({1'b0, heading})) + hc;
    if (hs_c < 0) x_c = hs_c + 25'(FULL_TURN * 32);
    else if (hs_c > 25'sd92160) x_c = hs_c - 25'sd1;
    else x_c = hs_c;
    red_c = 23'(FULL_TURN) << cmd.red_k;
  end

  // Index division and quarter-wave argument
  always_comb begin
    n_c   = NW'({heading, {B{1'b0}}}) + NW'(HALF_TURN);
    m_c   = n_c[NW-1:11];
    q0    = p[27+B:27];
    q45   = MW'({q0, 5'b0}) + MW'({q0, 3'b0}) + MW'({q0, 2'b0}) + MW'(q0);
    rem   = m_reg - q45;
    qf    = (rem >= MW'(45)) ? q0 + (B+1)'(1) : q0;
    angle = cmd.trig_sel ? idx + B'(QLEN) : idx;
    rr    = angle[B-2] ? QLEN - (B-1)'(angle[B-3:0]) : (B-1)'(angle[B-3:0]);
    u_c   = {rr, {(18-B){1'b0}}};
    t1    = 17'd42047 - p[32:16];
    t2    = 17'd102944 - p[32:16];
    s_raw = p[33:16];
    s_cap = (u_full || s_raw > 18'd65536) ? 18'd65536 : s_raw;
    rsum  = cmd.op == OP_R3 ? acc + p : acc - p;
    rsum  = rsum + 50'sd32768;
  end

  // Operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MUL_G:   begin ma = 27'(gd);  mb = 23'($signed({7'b0, g_scale})); end
      OP_GC:      begin ma = 27'(axd); mb = 23'($signed({7'b0, a_scale})); end
      OP_AX:      begin ma = 27'(ayd); mb = 23'($signed({7'b0, a_scale})); end
      OP_IDX_MUL: begin ma = $signed(27'(m_c)); mb = $signed(RECIP_45); end
      OP_P1:      begin ma = $signed({10'b0, u_c}); mb = $signed({6'b0, u_c}); end
      OP_P2:      begin ma = $signed({11'b0, p[31:16]}); mb = 23'sd4640; end
      OP_P3:      begin ma = $signed({11'b0, u2}); mb = $signed({6'b0, t1}); end
      OP_P4:      begin ma = $signed({10'b0, u}); mb = $signed({6'b0, t2}); end
      OP_R1:      begin ma = 27'(axs); mb = 23'(cos_v); end
      OP_R2:      begin ma = 27'(ays); mb = 23'(sin_v); end
      OP_R3:      begin ma = 27'(ays); mb = 23'(cos_v); end
      OP_R4:      begin ma = 27'(axs); mb = 23'(sin_v); end
      default:    begin ma = '0; mb = '0; end
    endcase
  end

  // Register the product
  always_ff @(posedge clk) begin
    p <= 50'(ma * mb);
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_reg <= in_data;
    end
  end

  // Work registers advanced by the step command
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_PREP: begin
        gd  <= (g_diff > -17'sd100 && g_diff < 17'sd100) ? '0 : g_diff;
        axd <= (ax_diff > -17'sd20 && ax_diff < 17'sd15) ? '0 : ax_diff;
        ayd <= (ay_diff > -17'sd20 && ay_diff < 17'sd15) ? '0 : ay_diff;
        cc  <= c_wrap;
      end
      OP_GC: gc <= gtmp[33:11];
      OP_AX: begin
        axs   <= rtmp[33:8];
        hsum  <= hs_c;
        w_neg <= hs_c < 0;
        w_pos <= hs_c > 25'sd92160;
        x     <= x_c[22:0];
      end
      OP_AY: ays <= rtmp[33:8];
      OP_RED: begin
        if (x >= red_c) x <= x - red_c;
      end
      OP_IDX_MUL: m_reg <= m_c;
      OP_IDX_FIX: idx <= qf[B-1:0];
      OP_P1: begin
        u      <= u_c;
        u_full <= u_c[16];
        s_neg  <= angle[B-1];
      end
      OP_P2: u2 <= p[31:16];
      OP_P5: begin
        if (cmd.trig_sel) cos_v <= s_neg ? -$signed(s_cap) : $signed(s_cap);
        else sin_v <= s_neg ? -$signed(s_cap) : $signed(s_cap);
      end
      OP_R2, OP_R4: acc <= p;
      OP_R3: an0 <= sat24(rsum);
      OP_R5: an1 <= sat24(rsum);
      OP_INT1: begin
        vn0 <= vel(accel0, an0, speed0);
        vn1 <= vel(accel1, an1, speed1);
      end
      default: ;
    endcase
  end

  // Navigation state: configuration writes and per-transaction commit
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_STOPPED;
      zero_x  <= '0;
      zero_y  <= '0;
      zero_g  <= '0;
      a_scale <= '0;
      g_scale <= '0;
      heading <= '0;
      accel0  <= '0;
      accel1  <= '0;
      speed0  <= '0;
      speed1  <= '0;
      pos0    <= '0;
      pos1    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MOTION_MODE: begin
          mode   <= cfg_data[1:0];
          accel0 <= '0;
          accel1 <= '0;
          speed0 <= '0;
          speed1 <= '0;
        end
        REG_ACCEL_ZERO_X: zero_x  <= cfg_data[15:0];
        REG_ACCEL_ZERO_Y: zero_y  <= cfg_data[15:0];
        REG_GYRO_ZERO_Z:  zero_g  <= cfg_data[15:0];
        REG_ACCEL_SCALE:  a_scale <= cfg_data[15:0];
        REG_GYRO_SCALE:   g_scale <= cfg_data[15:0];
        REG_START_HEADING: begin
          heading <= (cfg_data > 17'd92160) ? cfg_data - 17'd92160 : cfg_data;
          pos0    <= '0;
          pos1    <= '0;
        end
        default: ;
      endcase
    end else begin
      case (cmd.op)
        OP_HDG: begin
          if (w_pos) heading <= x[16:0] + 17'd1;
          else if (w_neg) heading <= x[16:0];
          else heading <= hsum[16:0];
        end
        OP_INT2: begin
          pos0   <= pos0 + pstep(speed0, vn0);
          pos1   <= pos1 + pstep(speed1, vn1);
          accel0 <= an0;
          accel1 <= an1;
          speed0 <= vn0;
          speed1 <= vn1;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= '{heading_out: heading, accel_north: accel0, accel_west: accel1,
                    speed_north: speed0, speed_west: speed1,
                    position_north: pos0, position_west: pos1};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/drhf_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// drhf_ctrl: heading fusion sequencer
// Accepts transactions, steps the datapath through its fixed schedule and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module drhf_ctrl import drhf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t     state;
  logic [4:0] step;
  dp_op_t     step_op;

  assign in_ready = (state == ST_IDLE);

  // Map schedule step to datapath operation
  always_comb begin
    case (step)
      5'd0:                            step_op = OP_PREP;
      5'd1:                            step_op = OP_MUL_G;
      5'd2:                            step_op = OP_GC;
      5'd3:                            step_op = OP_AX;
      5'd4:                            step_op = OP_AY;
      5'd5, 5'd6, 5'd7, 5'd8, 5'd9:    step_op = OP_RED;
      5'd10:                           step_op = OP_HDG;
      5'd11:                           step_op = OP_IDX_MUL;
      5'd12:                           step_op = OP_IDX_FIX;
      5'd13, 5'd18:                    step_op = OP_P1;
      5'd14, 5'd19:                    step_op = OP_P2;
      5'd15, 5'd20:                    step_op = OP_P3;
      5'd16, 5'd21:                    step_op = OP_P4;
      5'd17, 5'd22:                    step_op = OP_P5;
      5'd23:                           step_op = OP_R1;
      5'd24:                           step_op = OP_R2;
      5'd25:                           step_op = OP_R3;
      5'd26:                           step_op = OP_R4;
      5'd27:                           step_op = OP_R5;
      5'd28:                           step_op = OP_INT1;
      5'd29:                           step_op = OP_INT2;
      default:                         step_op = OP_IDLE;
    endcase
  end

  // Drive the datapath command
  always_comb begin
    cmd.capture  = in_valid && in_ready;
    cmd.op       = (state == ST_RUN) ? step_op : OP_IDLE;
    cmd.red_k    = 3'(5'd9 - step);
    cmd.trig_sel = (step >= 5'd18) && (step <= 5'd22);
    cmd.load_out = (state == ST_FIN) && (!out_valid || out_ready);
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          step <= '0;
          if (in_valid) state <= status.stopped ? ST_FIN : ST_RUN;
        end
        ST_RUN: begin
          if (step == LAST_STEP) state <= ST_FIN;
          else step <= step + 5'd1;
        end
        ST_FIN: begin
          if (!out_valid || out_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != ST_IDLE))
    else $error("sequencer stayed idle after a transaction");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result load did not raise out_valid");

  a_fin_free_exits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && !out_valid) |=> (state == ST_IDLE))
    else $error("finish state stuck with free output register");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step <= LAST_STEP))
    else $error("schedule step out of range");

endmodule
`default_nettype wire

// ----- rtl/core/dead_reckoning_heading_fusion.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dead_reckoning_heading_fusion: compass/gyro heading and position tracker
// Input channel in_valid/in_ready/in_data carries one sensor tick; output
// channel out_valid/out_ready/out_data carries the fused heading, north/west
// acceleration, speed and position after that tick.
// Configuration: cfg_we writes cfg_data into register cfg_index at once;
// write only while no transaction is in flight.
// A moving tick runs the full step schedule from acceptance to out_valid; a
// stopped tick skips it and goes straight to the finish state. The
// sequencer steps the single shared 27x23 multiplier through 16 dependent
// products plus the heading wrap.
// in_ready is high only while the sequencer is idle. The result sits in an
// output register, so a new tick is accepted while the previous result waits;
// if the receiver still stalls when the next result is done, the sequencer
// holds that result until the register frees.
// Reset (rst, synchronous) clears the configuration and navigation state,
// returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
module dead_reckoning_heading_fusion import drhf_pkg::*; #(
  parameter int TRIG_TABLE_BITS = TRIG_TABLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  drhf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath
  drhf_dp #(
    .TRIG_TABLE_BITS(TRIG_TABLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
